[hdl/ubis_pkg.sv]
// Package for the UART boot image sender: protocol codes, item kinds,
// phases and the result record. Used by uart_boot_image_sender.
package ubis_pkg;

  localparam logic [7:0] CODE_ACK = 8'h06;
  localparam logic [7:0] CODE_STX = 8'h02;
  localparam logic [7:0] CODE_SOH = 8'h01;
  localparam logic [7:0] RESET_ATTEMPTS = 8'd10;

  // Result queue sizing: one item yields at most this many results
  localparam int MaxResults = 3;
  localparam int QueueDepth = 4;

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_RX_BYTE = 2'd1,
    KIND_TIMEOUT = 2'd2,
    KIND_IMAGE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ACT_RESET  = 2'd0,
    ACT_TX     = 2'd1,
    ACT_FINISH = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_START = 2'd1,
    ST_NO_ACK   = 2'd2,
    ST_BAD_SUM  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_WAIT_STX = 3'd1,
    PH_WAIT_ACK = 3'd2,
    PH_SENDING  = 3'd3,
    PH_WAIT_SUM = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    CFG_ONE_WIRE     = 2'd0,
    CFG_MAX_ATTEMPTS = 2'd1,
    CFG_IMAGE_SIZE   = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] tx_byte;
    logic [1:0] status;
    logic       last;
  } result_t;

  function automatic result_t mk_res(action_t act, logic [7:0] tx, status_t st);
    result_t r;
    r.action  = act;
    r.tx_byte = tx;
    r.status  = st;
    r.last    = 1'b0;
    return r;
  endfunction

endpackage

[hdl/uart_boot_image_sender.sv]
// UART boot image sender, host side of the boot exchange with a target.
// Depends on ubis_pkg for codes, phases and the result record.
//
// Items enter on in_valid/in_stall and each is handled in the cycle it is
// accepted: the phase, attempt count, byte count, running XOR and echo count
// update at that edge and the item's results (zero to three) go into a
// four-entry result queue that feeds out_valid/out_stall, one result per
// unstalled cycle. An item is taken whenever the queue holds at most one
// result, so the block accepts one item per cycle as long as results are
// taken as fast as they come; the STX item (three header bytes) and a good
// checksum (two) hold the input while the queue drains. Configuration writes
// on cfg_we take effect at the next edge and belong between exchanges.
module uart_boot_image_sender
  import ubis_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_action,
  output logic [7:0]  out_tx_byte,
  output logic [1:0]  out_status,
  output logic        out_last
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  // Configuration
  logic        one_wire_r;
  logic [7:0]  max_attempts_r;
  logic [15:0] image_size_r;

  // Exchange state
  phase_t      phase_r, phase_nxt;
  logic [7:0]  attempts_r, attempts_nxt;
  logic [15:0] sent_r, sent_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [1:0]  echoes_r, echoes_nxt;

  // Result queue
  result_t         queue_r [QueueDepth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;

  result_t    res [MaxResults];
  logic [1:0] n_res;
  logic       in_acc, out_acc;
  logic       is_rx, is_rx_or_to;
  logic [15:0] sent_inc;

  assign in_stall  = (count_r > CntW'(QueueDepth - MaxResults));
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (count_r != '0);
  assign out_acc   = out_valid && !out_stall;

  assign out_action  = queue_r[rd_ptr_r].action;
  assign out_tx_byte = queue_r[rd_ptr_r].tx_byte;
  assign out_status  = queue_r[rd_ptr_r].status;
  assign out_last    = queue_r[rd_ptr_r].last;

  assign is_rx       = (in_kind == KIND_RX_BYTE);
  assign is_rx_or_to = is_rx || (in_kind == KIND_TIMEOUT);
  assign sent_inc    = sent_r + 16'd1;

  always_comb begin
    phase_nxt    = phase_r;
    attempts_nxt = attempts_r;
    sent_nxt     = sent_r;
    xor_nxt      = xor_r;
    echoes_nxt   = echoes_r;
    n_res        = 2'd0;
    for (int i = 0; i < MaxResults; i++) begin
      res[i] = mk_res(ACT_RESET, 8'h00, ST_OK);
    end

    if (in_acc) begin
      if (in_kind == KIND_START) begin
        phase_nxt    = PH_WAIT_STX;
        attempts_nxt = 8'd1;
        sent_nxt     = '0;
        xor_nxt      = '0;
        echoes_nxt   = '0;
        res[0]       = mk_res(ACT_RESET, 8'h00, ST_OK);
        n_res        = 2'd1;
      end else begin
        case (phase_r)
          PH_WAIT_STX: begin
            if (is_rx && in_data == CODE_STX) begin
              res[0]     = mk_res(ACT_TX, CODE_SOH, ST_OK);
              res[1]     = mk_res(ACT_TX, image_size_r[7:0], ST_OK);
              res[2]     = mk_res(ACT_TX, image_size_r[15:8], ST_OK);
              n_res      = 2'd3;
              echoes_nxt = one_wire_r ? 2'd3 : 2'd0;
              phase_nxt  = PH_WAIT_ACK;
            end else if (is_rx_or_to) begin
              if (attempts_r >= max_attempts_r) begin
                res[0]     = mk_res(ACT_FINISH, 8'h00, ST_NO_START);
                n_res      = 2'd1;
                phase_nxt  = PH_IDLE;
                echoes_nxt = '0;
              end else begin
                attempts_nxt = attempts_r + 8'd1;
                res[0]       = mk_res(ACT_RESET, 8'h00, ST_OK);
                n_res        = 2'd1;
              end
            end
          end
          PH_WAIT_ACK, PH_SENDING, PH_WAIT_SUM: begin
            if (is_rx_or_to && echoes_r != '0) begin
              // drop the echo of our own transmit
              echoes_nxt = echoes_r - 2'd1;
            end else if (phase_r == PH_WAIT_ACK) begin
              if (is_rx && in_data == CODE_ACK) begin
                sent_nxt  = '0;
                xor_nxt   = '0;
                phase_nxt = (image_size_r == '0) ? PH_WAIT_SUM : PH_SENDING;
              end else if (is_rx_or_to) begin
                res[0]     = mk_res(ACT_FINISH, 8'h00, ST_NO_ACK);
                n_res      = 2'd1;
                phase_nxt  = PH_IDLE;
                echoes_nxt = '0;
              end
            end else if (phase_r == PH_SENDING) begin
              if (in_kind == KIND_IMAGE) begin
                res[0]   = mk_res(ACT_TX, in_data, ST_OK);
                n_res    = 2'd1;
                xor_nxt  = xor_r ^ in_data;
                sent_nxt = sent_inc;
                if (one_wire_r && echoes_r != 2'd3) begin
                  echoes_nxt = echoes_r + 2'd1;
                end
                if (sent_inc >= image_size_r) begin
                  phase_nxt = PH_WAIT_SUM;
                end
              end
            end else begin
              if (is_rx && in_data == xor_r) begin
                res[0]     = mk_res(ACT_TX, CODE_ACK, ST_OK);
                res[1]     = mk_res(ACT_FINISH, 8'h00, ST_OK);
                n_res      = 2'd2;
                phase_nxt  = PH_IDLE;
                echoes_nxt = '0;
              end else if (is_rx_or_to) begin
                res[0]     = mk_res(ACT_FINISH, 8'h00, ST_BAD_SUM);
                n_res      = 2'd1;
                phase_nxt  = PH_IDLE;
                echoes_nxt = '0;
              end
            end
          end
          default: begin
            // idle: only a start item does anything
          end
        endcase
      end

      // mark the final result of this item
      case (n_res)
        2'd1:    res[0].last = 1'b1;
        2'd2:    res[1].last = 1'b1;
        2'd3:    res[2].last = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_wire_r     <= 1'b0;
      max_attempts_r <= RESET_ATTEMPTS;
      image_size_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ONE_WIRE:     one_wire_r     <= cfg_data[0];
        CFG_MAX_ATTEMPTS: max_attempts_r <= cfg_data[7:0];
        CFG_IMAGE_SIZE:   image_size_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      attempts_r <= '0;
      sent_r     <= '0;
      xor_r      <= '0;
      echoes_r   <= '0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      count_r    <= '0;
    end else begin
      phase_r    <= phase_nxt;
      attempts_r <= attempts_nxt;
      sent_r     <= sent_nxt;
      xor_r      <= xor_nxt;
      echoes_r   <= echoes_nxt;
      wr_ptr_r   <= wr_ptr_r + PtrW'(n_res);
      rd_ptr_r   <= rd_ptr_r + PtrW'(out_acc);
      count_r    <= count_r + CntW'(n_res) - CntW'(out_acc);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MaxResults; i++) begin
      if (i < int'(n_res)) begin
        queue_r[wr_ptr_r + PtrW'(i)] <= res[i];
      end
    end
  end

endmodule
